[design/assert_macros.svh]
// Assertion shorthands for the checker. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/pse_pkg.sv]
`timescale 1ns / 1ps

package pse_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int DIV_STEPS       = 8;
  localparam int POW_STEPS       = 7;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OPER = 2'd1,
    ST_DIVZ = 2'd2,
    ST_OVFL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIV,
    ALU_POW
  } alu_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_WAIT,
    S_PUSH,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic fault;
  } alu_rsp_t;

endpackage

[design/pse_cell.sv]
`timescale 1ns / 1ps

// One stack entry; shifts down on push, up on pop.
module pse_cell (
  input  logic               clk,
  input  pse_pkg::stk_op_t   op,
  input  logic [7:0]         from_above,
  input  logic [7:0]         from_below,
  output logic [7:0]         data
);

  always_ff @(posedge clk) begin
    case (op)
      pse_pkg::STK_PUSH: data <= from_above;
      pse_pkg::STK_POP:  data <= from_below;
      default:           data <= data;
    endcase
  end

endmodule

[design/pse_alu.sv]
`timescale 1ns / 1ps

// 8-bit arithmetic: add/sub/mul registered directly, restoring
// divide and square-and-multiply power iterated one step per cycle.
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  output pse_pkg::alu_rsp_t rsp,
  output logic [7:0]        result
);

  pse_pkg::alu_phase_t phase, phase_next;

  logic       done, done_next, fault;
  logic [7:0] res;
  logic [2:0] cnt;
  // divider
  logic [7:0] rem, quo, dvs;
  logic       neg;
  // power
  logic [7:0] acc, base;
  logic [6:0] expo;

  logic [15:0] ab_prod, acc_prod, sq_prod;
  logic [8:0]  shifted, diff;
  logic        ge;
  logic [7:0]  rem_n, quo_n;
  logic [7:0]  a_mag, b_mag;

  always_comb begin
    ab_prod  = {8'd0, a} * {8'd0, b};
    acc_prod = {8'd0, acc} * {8'd0, base};
    sq_prod  = {8'd0, base} * {8'd0, base};
    shifted  = {rem, quo[7]};
    diff     = shifted - {1'b0, dvs};
    ge       = shifted >= {1'b0, dvs};
    rem_n    = ge ? diff[7:0] : shifted[7:0];
    quo_n    = {quo[6:0], ge};
    a_mag    = a[7] ? (8'd0 - a) : a;
    b_mag    = b[7] ? (8'd0 - b) : b;
  end

  always_comb begin
    phase_next = phase;
    done_next  = 1'b0;
    case (phase)
      pse_pkg::ALU_IDLE: begin
        if (req.start && req.op == pse_pkg::OP_DIV && b != 8'd0) begin
          phase_next = pse_pkg::ALU_DIV;
        end else if (req.start && req.op == pse_pkg::OP_POW && !b[7]) begin
          phase_next = pse_pkg::ALU_POW;
        end else begin
          done_next = req.start;
        end
      end
      pse_pkg::ALU_DIV: begin
        if (cnt == 3'(pse_pkg::DIV_STEPS - 1)) begin
          phase_next = pse_pkg::ALU_IDLE;
          done_next  = 1'b1;
        end
      end
      pse_pkg::ALU_POW: begin
        if (cnt == 3'(pse_pkg::POW_STEPS - 1)) begin
          phase_next = pse_pkg::ALU_IDLE;
          done_next  = 1'b1;
        end
      end
      default: phase_next = pse_pkg::ALU_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = done;
    rsp.fault = fault;
    result    = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pse_pkg::ALU_IDLE;
      done  <= 1'b0;
      fault <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= done_next;
      case (phase)
        pse_pkg::ALU_IDLE: begin
          if (req.start) begin
            // divide by zero, or zero to a negative power
            fault <= (req.op == pse_pkg::OP_DIV && b == 8'd0) ||
                     (req.op == pse_pkg::OP_POW && b[7] && a == 8'd0);
            case (req.op)
              pse_pkg::OP_ADD: begin
                res <= a + b;
              end
              pse_pkg::OP_SUB: begin
                res <= a - b;
              end
              pse_pkg::OP_MUL: begin
                res <= ab_prod[7:0];
              end
              pse_pkg::OP_DIV: begin
                if (b != 8'd0) begin
                  rem <= 8'd0;
                  quo <= a_mag;
                  dvs <= b_mag;
                  neg <= a[7] ^ b[7];
                  cnt <= 3'd0;
                end
              end
              pse_pkg::OP_POW: begin
                if (b[7]) begin
                  // negative exponent: only bases 1 and -1 survive
                  if (a == 8'h01) begin
                    res <= 8'h01;
                  end else if (a == 8'hFF) begin
                    res <= b[0] ? 8'hFF : 8'h01;
                  end else begin
                    res <= 8'h00;
                  end
                end else begin
                  acc  <= 8'h01;
                  base <= a;
                  expo <= b[6:0];
                  cnt  <= 3'd0;
                end
              end
              default: begin
                res <= 8'h00;
              end
            endcase
          end
        end
        pse_pkg::ALU_DIV: begin
          rem <= rem_n;
          quo <= quo_n;
          cnt <= cnt + 3'd1;
          if (cnt == 3'(pse_pkg::DIV_STEPS - 1)) begin
            // -128 / -1 wraps back to -128 here
            res <= neg ? (8'd0 - quo_n) : quo_n;
          end
        end
        pse_pkg::ALU_POW: begin
          if (expo[0]) acc <= acc_prod[7:0];
          base <= sq_prod[7:0];
          expo <= {1'b0, expo[6:1]};
          cnt  <= cnt + 3'd1;
          if (cnt == 3'(pse_pkg::POW_STEPS - 1)) begin
            res <= expo[0] ? acc_prod[7:0] : acc;
          end
        end
        default: begin
          res <= res;
        end
      endcase
    end
  end

endmodule

[design/postfix_stack_evaluator.sv]
`timescale 1ns / 1ps

// Postfix (RPN) evaluator on 8-bit signed values, one character per request.
// Digits and other non-operator bytes push (code - '0'); + - * / ^ pop the
// right then the left operand and push the wrapped result. An empty pop reads
// 0; a push onto a full stack is dropped and flags overflow (status 3).
// '%', '(' and ')' abort with status 1; divide by zero and zero to a negative
// power abort with status 2; after an abort the rest of the expression is
// skipped and the result value is 0. The request with last_char set produces
// one result (top of stack, or 0) and clears the stack for the next
// expression. One request is in flight at a time. Pushes and skipped
// characters go straight to the stack or back to idle; + - * / ^ pop two
// operands into the shared ALU, whose / and ^ iterate through its 8-step
// restoring divider and 7-step square-and-multiply unit. The last character
// loads the output register once it is free; the register holds the result
// while the next expression streams in. The stack is a row of STACK_DEPTH
// shifting cells with the top at cell 0; it needs no clearing pass after reset.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              last_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [7:0] value,
  output logic [1:0]        status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  pse_pkg::seq_state_t state, state_next;

  logic [7:0]       ch;
  logic             last;
  logic [7:0]       opa, opb, result;
  logic [CW-1:0]    count;
  pse_pkg::status_t err;
  logic [7:0]       out_value;
  pse_pkg::status_t out_status;

  pse_pkg::stk_op_t  stk_op;
  pse_pkg::alu_req_t alu_req;
  pse_pkg::alu_rsp_t alu_rsp;
  logic [7:0]        alu_result;

  logic [7:0] cell_data [STACK_DEPTH];
  logic [7:0] top_val;
  logic       full, aborted, bad_char, is_op, out_free;

  // operator byte -> ALU opcode
  function automatic pse_pkg::alu_op_t decode_op(input logic [7:0] c);
    pse_pkg::alu_op_t op;
    op = pse_pkg::OP_ADD;
    case (c)
      pse_pkg::CH_MINUS: op = pse_pkg::OP_SUB;
      pse_pkg::CH_STAR:  op = pse_pkg::OP_MUL;
      pse_pkg::CH_SLASH: op = pse_pkg::OP_DIV;
      pse_pkg::CH_CARET: op = pse_pkg::OP_POW;
      default:           op = pse_pkg::OP_ADD;
    endcase
    return op;
  endfunction

  always_comb begin
    top_val  = (count == '0) ? 8'd0 : cell_data[0];
    full     = count == CW'(STACK_DEPTH);
    aborted  = (err == pse_pkg::ST_OPER) || (err == pse_pkg::ST_DIVZ);
    bad_char = char_code inside {pse_pkg::CH_PCT, pse_pkg::CH_LPAR, pse_pkg::CH_RPAR};
    is_op    = char_code inside {pse_pkg::CH_PLUS, pse_pkg::CH_MINUS, pse_pkg::CH_STAR,
                                 pse_pkg::CH_SLASH, pse_pkg::CH_CARET};
    out_free = !out_valid || out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pse_pkg::S_IDLE: begin
        if (in_valid) begin
          if (aborted || bad_char) begin
            state_next = last_char ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
          end else if (is_op) begin
            state_next = pse_pkg::S_POP_B;
          end else begin
            state_next = pse_pkg::S_PUSH;
          end
        end
      end
      pse_pkg::S_POP_B: state_next = pse_pkg::S_POP_A;
      pse_pkg::S_POP_A: state_next = pse_pkg::S_EXEC;
      pse_pkg::S_EXEC:  state_next = pse_pkg::S_WAIT;
      pse_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          if (alu_rsp.fault) begin
            state_next = last ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
          end else begin
            state_next = pse_pkg::S_PUSH;
          end
        end
      end
      pse_pkg::S_PUSH:   state_next = last ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
      pse_pkg::S_FINISH: if (out_free) state_next = pse_pkg::S_IDLE;
      default:           state_next = pse_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready      = 1'b0;
    stk_op        = pse_pkg::STK_HOLD;
    alu_req.start = 1'b0;
    alu_req.op    = decode_op(ch);
    case (state)
      pse_pkg::S_IDLE:  in_ready = 1'b1;
      pse_pkg::S_POP_B,
      pse_pkg::S_POP_A: if (count != '0) stk_op = pse_pkg::STK_POP;
      pse_pkg::S_EXEC:  alu_req.start = 1'b1;
      pse_pkg::S_PUSH:  if (!full) stk_op = pse_pkg::STK_PUSH;
      default:          stk_op = pse_pkg::STK_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pse_pkg::S_IDLE;
      count     <= '0;
      err       <= pse_pkg::ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a load in S_FINISH takes over the drain of the old result
      if (out_valid && out_ready && state != pse_pkg::S_FINISH) out_valid <= 1'b0;
      case (state)
        pse_pkg::S_IDLE: begin
          if (in_valid) begin
            ch     <= char_code;
            last   <= last_char;
            result <= char_code - pse_pkg::CH_ZERO;
            if (!aborted && bad_char) err <= pse_pkg::ST_OPER;
          end
        end
        pse_pkg::S_POP_B: begin
          opb <= top_val;
          if (count != '0) count <= count - CW'(1);
        end
        pse_pkg::S_POP_A: begin
          opa <= top_val;
          if (count != '0) count <= count - CW'(1);
        end
        pse_pkg::S_WAIT: begin
          if (alu_rsp.done) begin
            if (alu_rsp.fault) err <= pse_pkg::ST_DIVZ;
            else               result <= alu_result;
          end
        end
        pse_pkg::S_PUSH: begin
          if (full) begin
            if (err == pse_pkg::ST_OK) err <= pse_pkg::ST_OVFL;
          end else begin
            count <= count + CW'(1);
          end
        end
        pse_pkg::S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_value  <= aborted ? 8'd0 : top_val;
            out_status <= err;
            count      <= '0;
            err        <= pse_pkg::ST_OK;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // stack: cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] above, below;
    if (i == 0) begin : g_top
      assign above = result;
    end else begin : g_mid
      assign above = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = 8'd0;
    end else begin : g_inner
      assign below = cell_data[i+1];
    end
    pse_cell u_cell (
      .clk        (clk),
      .op         (stk_op),
      .from_above (above),
      .from_below (below),
      .data       (cell_data[i])
    );
  end

  pse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (opa),
    .b      (opb),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  assign value  = out_value;
  assign status = out_status;

endmodule

[design/pse_checker.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pse_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              last_char,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] value,
  input logic [1:0]        status
);

  // aborted expressions report a zero value
  `AST_IMPL(a_abort_zero,
            out_valid && (status == pse_pkg::ST_OPER || status == pse_pkg::ST_DIVZ),
            value == 8'sd0)

  // a waiting result holds
  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(status))

  // reset empties the output register
  `AST_NEXT_ALWAYS(a_rst_idle, rst, !out_valid)

  // one request in flight: the last character keeps the input closed next cycle
  `AST_NEXT(a_last_busy, in_valid && in_ready && last_char, !in_ready)

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

[tb/sv/postfix_stack_evaluator_tb.sv]
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb;
  import pse_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int CHAR_TARGET = 650;  // accepted characters
  localparam int LONG_HOLD   = 1000; // receiver back-pressure stretch, cycles
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE      = 40;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        char_code;
  logic              last_char;
  logic              out_valid;
  logic              out_ready;
  logic signed [7:0] value;
  logic [1:0]        status;

  postfix_stack_evaluator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_operator(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
           c == CH_CARET;
  endfunction

  // characters that kill the expression outright
  function automatic bit is_abort(logic [7:0] c);
    return c == CH_PCT || c == CH_LPAR || c == CH_RPAR;
  endfunction

  function automatic int to_int(logic [7:0] v);
    return v[7] ? int'(v) - 256 : int'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Shadow evaluator: mirrors the stack and error flag, queues the result
  // every last character should produce, and matches results as they leave.
  // ---------------------------------------------------------------------------
  class rpn_shadow;
    logic [7:0]  cells [STACK_DEPTH];
    int unsigned depth;
    status_t     err;
    logic [7:0]  due_values [$];
    status_t     due_status [$];
    int unsigned errors, exprs, aborts, overflows, live_chars, sent_chars;

    function new();
      depth = 0;
      err   = ST_OK;
    endfunction

    function bit is_dead();
      return err == ST_OPER || err == ST_DIVZ;
    endfunction

    // empty pop reads as 0 and leaves the stack empty
    function logic [7:0] pull();
      if (depth == 0) return 8'h00;
      depth--;
      return cells[depth];
    endfunction

    // push onto a full stack is dropped; overflow only sticks if no error yet
    function void place(logic [7:0] v);
      if (depth >= STACK_DEPTH) begin
        if (err == ST_OK) err = ST_OVFL;
      end else begin
        cells[depth] = v;
        depth++;
      end
    endfunction

    // exact power wrapped to 8 bits; -1 flags zero to a negative power
    function int raise_pow(int base, int ex);
      int acc;
      int k;
      if (ex < 0) begin
        if (base == 0) return -1;
        if (base == 1) return 1;
        if (base == -1) return ((-ex) & 1) ? 255 : 1;
        return 0;
      end
      acc = 1;
      for (k = 0; k < ex; k++) acc = (acc * (base & 255)) & 255;
      return acc;
    endfunction

    function void eval_symbol(logic [7:0] c);
      int a, b, r;
      if (is_abort(c)) begin
        err = ST_OPER;
        return;
      end
      if (!is_operator(c)) begin
        place(c - CH_ZERO);
        return;
      end
      // right operand comes off first
      b = to_int(pull());
      a = to_int(pull());
      case (c)
        CH_PLUS:  r = a + b;
        CH_MINUS: r = a - b;
        CH_STAR:  r = a * b;
        CH_SLASH: begin
          if (b == 0) begin
            err = ST_DIVZ;
            return;
          end
          r = a / b;  // truncates toward zero; -128 / -1 wraps below
        end
        default: begin
          r = raise_pow(a, b);
          if (r < 0) begin
            err = ST_DIVZ;
            return;
          end
        end
      endcase
      place(r[7:0]);
    endfunction

    // called once per accepted input request
    function void take_char(logic [7:0] c, logic last);
      logic [7:0] top;
      sent_chars++;
      if (!is_dead()) begin
        eval_symbol(c);
        live_chars++;
      end
      if (last) begin
        top = is_dead() ? 8'h00 : pull();
        due_values.push_back(top);
        due_status.push_back(err);
        if (is_dead()) aborts++;
        if (err == ST_OVFL) overflows++;
        exprs++;
        depth = 0;
        err   = ST_OK;
      end
    endfunction

    // called once per accepted output request
    function void match_result(logic [7:0] v, logic [1:0] s);
      logic [7:0] want_v;
      status_t    want_s;
      if (due_values.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got value %0d status %0d",
                 $time, $signed(v), s);
        errors++;
        return;
      end
      want_v = due_values.pop_front();
      want_s = due_status.pop_front();
      if (v !== want_v) begin
        $display("%0t ns: value mismatch, expected %0d, got %0d",
                 $time, $signed(want_v), $signed(v));
        errors++;
      end
      if (s !== want_s) begin
        $display("%0t ns: status mismatch, expected %0d, got %0d", $time, want_s, s);
        errors++;
      end
    endfunction
  endclass

  rpn_shadow shadow;

  // knobs for the driver (gap_pct) and the receiver (stall_pct, hold_output)
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_output;

  logic [7:0]  expr_q [$];

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold on request so the
  // output register fills and the block has to stall its input.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_output = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.match_result(value, status);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] digit(int n);
    return CH_ZERO + n[7:0];
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  // mostly decimal digits, sometimes any byte that pushes (wide values,
  // negative exponents)
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(0, 9) < 7) return digit($urandom_range(0, 9));
    do c = 8'($urandom_range(0, 255)); while (is_operator(c) || is_abort(c));
    return c;
  endfunction

  // One request; drives at the falling edge, waits for acceptance at the
  // rising edge, returns at the next falling edge.
  task automatic send_char(input logic [7:0] c, input logic l);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= l;
    do @(posedge clk); while (!in_ready);
    shadow.take_char(c, l);
    @(negedge clk);
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_char(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Valid postfix with random content. Now and then an operator is issued
  // with fewer than two entries to hit the empty pop path.
  task automatic build_wellformed(input int n);
    int depth;
    int k;
    depth = 0;
    expr_q.delete();
    for (k = 0; k < n; k++) begin
      if (depth >= 2 && $urandom_range(0, 1) == 1) begin
        expr_q.push_back(pick_operator());
        depth--;
      end else if ($urandom_range(0, 19) == 0) begin
        expr_q.push_back(pick_operator());
        if (depth > 0) depth--;
      end else begin
        expr_q.push_back(pick_operand());
        depth++;
      end
    end
    while (depth > 1) begin
      expr_q.push_back(pick_operator());
      depth--;
    end
  endtask

  // well-formed body with an abort dropped in somewhere
  task automatic build_broken();
    int pos;
    build_wellformed($urandom_range(2, 10));
    pos = $urandom_range(0, expr_q.size());
    case ($urandom_range(0, 3))
      0: expr_q.insert(pos, CH_PCT);
      1: expr_q.insert(pos, CH_LPAR);
      2: expr_q.insert(pos, CH_RPAR);
      default: begin
        // divide by a freshly pushed zero
        expr_q.insert(pos, CH_SLASH);
        expr_q.insert(pos, CH_ZERO);
      end
    endcase
  endtask

  task automatic build_noise();
    expr_q.delete();
    repeat ($urandom_range(1, 5)) expr_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Fill past the top of the stack; optionally spoil it with '%' so the
  // invalid-operator code overrides the overflow flag.
  task automatic build_overflow(input bit spoil);
    expr_q.delete();
    repeat (STACK_DEPTH + $urandom_range(1, 6)) expr_q.push_back(pick_operand());
    repeat ($urandom_range(0, 3)) expr_q.push_back(pick_operator());
    if (spoil) expr_q.push_back(CH_PCT);
    expr_q.push_back(pick_operand());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n_expr;
    int roll;
    int waited;
    shadow      = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    char_code   = 8'h00;
    last_char   = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_output = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corner cases, light idling on both sides
    gap_pct   = 25;
    stall_pct = 25;
    expr_q = '{digit(3), CH_PLUS};                              // add with empty pop
    send_expr();
    expr_q = '{8'h00, 8'hFF, CH_STAR};                          // byte extremes
    send_expr();
    expr_q = '{digit(8), digit(0), CH_SLASH};                   // divide by zero
    send_expr();
    expr_q = '{8'hB0, digit(0), digit(1), CH_MINUS, CH_SLASH};  // -128 / -1 wraps
    send_expr();
    expr_q = '{digit(2), digit(7), CH_CARET};                   // 2^7 wraps
    send_expr();
    // (-1) ^ (-9): byte 39 pushes -9
    expr_q = '{digit(0), digit(1), CH_MINUS, 8'd39, CH_CARET};
    send_expr();
    expr_q = '{digit(0), 8'd46, CH_CARET};                      // 0 ^ -2 aborts
    send_expr();
    expr_q = '{CH_PCT, digit(5)};                               // skipped after abort
    send_expr();
    expr_q = '{CH_LPAR};
    send_expr();

    // random expressions, mostly well-formed
    n_expr = 0;
    while (shadow.sent_chars < CHAR_TARGET) begin
      if (n_expr % 8 == 0) begin
        roll      = $urandom_range(0, 2);
        gap_pct   = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
        roll      = $urandom_range(0, 2);
        stall_pct = (roll == 0) ? 0 : (roll == 1) ? 15 : 40;
      end
      // no idling at all toward the end of the run
      if (shadow.sent_chars + 90 >= CHAR_TARGET) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      // long output hold while short expressions keep coming
      if (n_expr == 12) hold_output = 1'b1;

      roll = $urandom_range(0, 99);
      if (n_expr == 6) build_overflow(1'b0);
      else if (n_expr == 20) build_overflow(1'b1);
      else if (roll < 70) build_wellformed($urandom_range(1, 12));
      else if (roll < 88) build_broken();
      else build_noise();
      send_expr();
      n_expr++;
    end
    in_valid <= 1'b0;

    // drain, then allow for the output register load
    waited = 0;
    while (shadow.due_values.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);

    if (shadow.due_values.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived",
               $time, shadow.due_values.size());
      shadow.errors += shadow.due_values.size();
    end

    $display("run covered %0d expressions over %0d characters (%0d evaluated):",
             shadow.exprs, shadow.sent_chars, shadow.live_chars);
    $display("  %0d aborted, %0d with the stack overflowed",
             shadow.aborts, shadow.overflows);
    if (shadow.errors == 0) begin
      $display("postfix_stack_evaluator_tb: clean");
    end else begin
      $display("postfix_stack_evaluator_tb: errors");
    end
    $finish;
  end

  // hard stop if the handshake hangs
  initial begin
    #10_000_000;
    $display("timeout at %0t ns", $time);
    $display("postfix_stack_evaluator_tb: errors");
    $finish;
  end

endmodule
